// ----- hdl/cbb_pkg.sv -----
// ----------------------------------------------------------------------------
// cbb_pkg: shared types for the clip stack bounding box accumulator
// Item structs, action codes, rectangle type and rectangle intersect/union.
// ----------------------------------------------------------------------------
package cbb_pkg;

	localparam int STACK_DEPTH_DEF = 96;
	localparam int CLIP_W          = 10;
	localparam int IGN_W           = 8;
	localparam logic [CLIP_W-1:0] CLIP_MAX = {CLIP_W{1'b1}};
	localparam logic [IGN_W-1:0]  IGN_MAX  = {IGN_W{1'b1}};

	typedef enum logic [2:0] {
		ACT_CLEAR   = 3'd0,
		ACT_DRAW    = 3'd1,
		ACT_CLIP    = 3'd2,
		ACT_POP     = 3'd3,
		ACT_MASK    = 3'd4,
		ACT_END_IGN = 3'd5,
		ACT_TILE    = 3'd6
	} action_t;

	typedef struct packed {
		logic signed [31:0] x0;
		logic signed [31:0] y0;
		logic signed [31:0] x1;
		logic signed [31:0] y1;
	} rect_t;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] rect_x0;
		logic signed [31:0] rect_y0;
		logic signed [31:0] rect_x1;
		logic signed [31:0] rect_y1;
	} evt_item_t;

	typedef struct packed {
		logic signed [31:0] box_x0;
		logic signed [31:0] box_y0;
		logic signed [31:0] box_x1;
		logic signed [31:0] box_y1;
		logic [CLIP_W-1:0]  clip_level;
		logic [IGN_W-1:0]   ignore_level;
		logic               pop_underflow;
		logic               over_depth;
	} res_item_t;

	// Shift control for the stack cells.
	typedef struct packed {
		logic push;
		logic pop;
	} stk_ctrl_t;

	function automatic logic rect_empty(rect_t r);
		return (r.x0 == r.x1) || (r.y0 == r.y1);
	endfunction

	function automatic logic rect_inf(rect_t r);
		return (r.x0 > r.x1) || (r.y0 > r.y1);
	endfunction

	function automatic rect_t rect_isect(rect_t a, rect_t b);
		rect_t r;
		r = a;
		if (rect_empty(a)) begin
			r = a;
		end else if (rect_empty(b)) begin
			r = '0;
		end else if (rect_inf(b)) begin
			r = a;
		end else if (rect_inf(a)) begin
			r = b;
		end else begin
			r.x0 = (a.x0 > b.x0) ? a.x0 : b.x0;
			r.y0 = (a.y0 > b.y0) ? a.y0 : b.y0;
			r.x1 = (a.x1 < b.x1) ? a.x1 : b.x1;
			r.y1 = (a.y1 < b.y1) ? a.y1 : b.y1;
			if ((r.x1 < r.x0) || (r.y1 < r.y0)) begin
				r = '0;
			end
		end
		return r;
	endfunction

	function automatic rect_t rect_union(rect_t a, rect_t b);
		rect_t r;
		r = a;
		if (rect_empty(b)) begin
			r = a;
		end else if (rect_empty(a)) begin
			r = b;
		end else if (rect_inf(a)) begin
			r = a;
		end else if (rect_inf(b)) begin
			r = b;
		end else begin
			r.x0 = (a.x0 < b.x0) ? a.x0 : b.x0;
			r.y0 = (a.y0 < b.y0) ? a.y0 : b.y0;
			r.x1 = (a.x1 > b.x1) ? a.x1 : b.x1;
			r.y1 = (a.y1 > b.y1) ? a.y1 : b.y1;
		end
		return r;
	endfunction

endpackage

// ----- hdl/cbb_cell.sv -----
// ----------------------------------------------------------------------------
// cbb_cell: one clip stack entry
// Takes its upper neighbor's rectangle on a push, its lower one's on a pop.
// ----------------------------------------------------------------------------
module cbb_cell import cbb_pkg::*; (
	input  logic      clk,
	input  stk_ctrl_t ctrl,
	input  rect_t     prev_rect,
	input  rect_t     next_rect,
	output rect_t     rect
);

	rect_t rect_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			rect_q <= prev_rect;
		end else if (ctrl.pop) begin
			rect_q <= next_rect;
		end
	end

	assign rect = rect_q;

endmodule

// ----- hdl/cbb_stack.sv -----
// ----------------------------------------------------------------------------
// cbb_stack: clip stack built as a chain of shifting cells
// Cell 0 is always the top of the stack; deeper entries sit further down.
// ----------------------------------------------------------------------------
module cbb_stack import cbb_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic      clk,
	input  stk_ctrl_t ctrl,
	input  rect_t     push_rect,
	output rect_t     top_rect
);

	rect_t cell_rect [STACK_DEPTH];

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		rect_t prev_r;
		rect_t next_r;

		if (i == 0) begin : g_first
			assign prev_r = push_rect;
		end else begin : g_mid
			assign prev_r = cell_rect[i-1];
		end

		// The bottom cell holds its value on a pop.
		if (i == STACK_DEPTH - 1) begin : g_last
			assign next_r = cell_rect[i];
		end else begin : g_rest
			assign next_r = cell_rect[i+1];
		end

		cbb_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.prev_rect (prev_r),
			.next_rect (next_r),
			.rect      (cell_rect[i])
		);
	end

	assign top_rect = cell_rect[0];

endmodule

// ----- hdl/clip_stack_bbox_accumulator.sv -----
// ----------------------------------------------------------------------------
// clip_stack_bbox_accumulator: clip stack and running bounding box
// Clips draw rectangles to the clip stack top and unions them into a box.
// ----------------------------------------------------------------------------
// Usage:
// Events enter on the evt channel (evt_valid, evt_stall, evt). Each event is
// an action code and a rectangle in signed 24.8 fixed point. Every accepted
// item produces exactly one result item on the res channel (res_valid,
// res_stall, res), carrying the bounding box, clip and ignore levels and the
// underflow and overflow flags as they stand after that event.
// The result of an item is registered at the same edge that accepts it.
// Throughput is one item per cycle while evt_stall is low; the clip state of
// one event is needed by the next, and it is settled combinationally by
// compares against the stack top cell and the box register.
// The clip stack is a chain of STACK_DEPTH cells that all shift together on a
// push or a pop, so the top entry is always in the first cell.
// The result sits in an output register. While res_stall holds a waiting
// result, evt_stall is raised and no new item is taken; the result stays put.
// Reset (arst_n low) empties the box, zeroes both levels and drops res_valid.
// Stack cell contents are not cleared; an entry is only read after a push.
// ----------------------------------------------------------------------------
module clip_stack_bbox_accumulator import cbb_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      evt_valid,
	output logic      evt_stall,
	input  evt_item_t evt,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res
);

	localparam logic [CLIP_W-1:0] DEPTH_L = CLIP_W'(STACK_DEPTH);

	rect_t             box_q;
	logic [CLIP_W-1:0] depth_q;
	logic [IGN_W-1:0]  ign_q;
	res_item_t         res_q;
	logic              res_valid_q;

	rect_t             evt_rect;
	rect_t             top_rect;
	rect_t             clipped;
	rect_t             box_n;
	logic [CLIP_W-1:0] depth_n;
	logic [IGN_W-1:0]  ign_n;
	logic              under_n;
	logic              accept;
	logic              top_ok;
	logic              in_range;
	stk_ctrl_t         stk_ctrl;

	// Hold off the sender while a finished result still waits downstream.
	assign evt_stall = res_valid_q && res_stall;
	assign accept    = evt_valid && !evt_stall;

	assign evt_rect.x0 = evt.rect_x0;
	assign evt_rect.y0 = evt.rect_y0;
	assign evt_rect.x1 = evt.rect_x1;
	assign evt_rect.y1 = evt.rect_y1;

	cbb_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk       (clk),
		.ctrl      (stk_ctrl),
		.push_rect (clipped),
		.top_rect  (top_rect)
	);

	// The stack top is only meaningful while the depth is within capacity.
	assign in_range = (depth_q <= DEPTH_L);
	assign top_ok   = (depth_q != '0) && in_range;
	assign clipped  = top_ok ? rect_isect(evt_rect, top_rect) : evt_rect;

	always_comb begin
		box_n         = box_q;
		depth_n       = depth_q;
		ign_n         = ign_q;
		under_n       = 1'b0;
		stk_ctrl.push = 1'b0;
		stk_ctrl.pop  = 1'b0;
		case (evt.action)
			ACT_CLEAR: begin
				box_n   = '0;
				depth_n = '0;
				ign_n   = '0;
			end
			ACT_DRAW, ACT_TILE: begin
				// A tile draw sees the ignore level from before its increment.
				if (in_range && (ign_q == '0)) begin
					box_n = rect_union(box_q, clipped);
				end
				if ((evt.action == ACT_TILE) && (ign_q != IGN_MAX)) begin
					ign_n = ign_q + 1'b1;
				end
			end
			ACT_CLIP, ACT_MASK: begin
				if (depth_q != CLIP_MAX) begin
					depth_n = depth_q + 1'b1;
				end
				// Past capacity the level still counts, but nothing is stored.
				stk_ctrl.push = accept && (depth_q < DEPTH_L);
				if ((evt.action == ACT_MASK) && (ign_q != IGN_MAX)) begin
					ign_n = ign_q + 1'b1;
				end
			end
			ACT_POP: begin
				if (depth_q != '0) begin
					depth_n      = depth_q - 1'b1;
					stk_ctrl.pop = accept && in_range;
				end else begin
					under_n = 1'b1;
				end
			end
			ACT_END_IGN: begin
				if (ign_q != '0) begin
					ign_n = ign_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q       <= '0;
			depth_q     <= '0;
			ign_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				box_q       <= box_n;
				depth_q     <= depth_n;
				ign_q       <= ign_n;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.box_x0        <= box_n.x0;
			res_q.box_y0        <= box_n.y0;
			res_q.box_x1        <= box_n.x1;
			res_q.box_y1        <= box_n.y1;
			res_q.clip_level    <= depth_n;
			res_q.ignore_level  <= ign_n;
			res_q.pop_underflow <= under_n;
			res_q.over_depth    <= (depth_n > DEPTH_L);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- hdl/cbb_checker.sv -----
// ----------------------------------------------------------------------------
// cbb_checker: port-level checks for the clip stack bbox accumulator
// Watches the item channels and the result fields over time.
// ----------------------------------------------------------------------------
module cbb_checker import cbb_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	input logic      evt_valid,
	input logic      evt_stall,
	input evt_item_t evt,
	input logic      res_valid,
	input logic      res_stall,
	input res_item_t res
);

	localparam logic [CLIP_W-1:0] DEPTH_L = CLIP_W'(STACK_DEPTH);

	// A stalled result item stays in place.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(res)))
		else $error("result item changed while stalled");

	// Every accepted event yields a result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && !evt_stall) |=> res_valid)
		else $error("no result after an accepted event");

	// A clear returns box and levels to their reset values.
	assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && !evt_stall && (evt.action == ACT_CLEAR)) |=>
		((res.clip_level == '0) && (res.ignore_level == '0) &&
		 (res.box_x0 == '0) && (res.box_y0 == '0) &&
		 (res.box_x1 == '0) && (res.box_y1 == '0)))
		else $error("clear did not reset the state");

	// Underflow is only reported with an empty stack.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.pop_underflow) |-> (res.clip_level == '0))
		else $error("pop underflow with nonzero clip level");

	// The overflow flag tracks the clip level against the stack capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.over_depth == (res.clip_level > DEPTH_L)))
		else $error("over_depth disagrees with clip level");

endmodule

bind clip_stack_bbox_accumulator cbb_checker #(
	.STACK_DEPTH (STACK_DEPTH)
) u_cbb_checker (.*);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for clip_stack_bbox_accumulator
// Drives rendering events with random gaps and result stalls, predicts every
// result item from its own copy of the clip stack, levels and bounding box,
// and checks each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

	import cbb_pkg::*;

	localparam int STACK_DEPTH = STACK_DEPTH_DEF;

	// Action 7 has no meaning; the block must only report its state.
	localparam logic [2:0] ACT_UNUSED = 3'd7;

	localparam logic signed [31:0] MIN_C = 32'sh8000_0000;
	localparam logic signed [31:0] MAX_C = 32'sh7FFF_FFFF;

	localparam int RANDOM_ITEMS = 200;
	localparam int MAX_GAP      = 13;
	// The receiver holds off once for a long stretch after this many results.
	localparam int HOLD_AT      = 400;
	localparam int LONG_HOLD    = 250;
	// Results come from an output register, so a short tail catches stray results.
	localparam int TAIL_CYCLES  = 16;
	localparam int CYCLE_LIMIT  = 400000;

	// The scoreboard keeps its own copy of the clip stack, the two levels and
	// the running box. Every accepted event advances that copy and queues the
	// result item the block has to report for it.
	class bbox_scoreboard;
		rect_t       box;
		rect_t       clip_cells[STACK_DEPTH];
		int unsigned clip_depth;
		int unsigned ignore_depth;
		res_item_t   reports_due[$];
		int          errors;

		function new();
			box          = '0;
			clip_depth   = 0;
			ignore_depth = 0;
			errors       = 0;
		endfunction

		function bit is_void(rect_t r);
			return (r.x0 == r.x1) || (r.y0 == r.y1);
		endfunction

		function bit is_unbounded(rect_t r);
			return (r.x0 > r.x1) || (r.y0 > r.y1);
		endfunction

		function rect_t clamp_rect(rect_t a, rect_t b);
			rect_t c;
			if (is_void(a)) begin
				return a;
			end
			if (is_void(b)) begin
				return '0;
			end
			if (is_unbounded(b)) begin
				return a;
			end
			if (is_unbounded(a)) begin
				return b;
			end
			c.x0 = (a.x0 > b.x0) ? a.x0 : b.x0;
			c.y0 = (a.y0 > b.y0) ? a.y0 : b.y0;
			c.x1 = (a.x1 < b.x1) ? a.x1 : b.x1;
			c.y1 = (a.y1 < b.y1) ? a.y1 : b.y1;
			if ((c.x1 < c.x0) || (c.y1 < c.y0)) begin
				c = '0;
			end
			return c;
		endfunction

		function rect_t grow_rect(rect_t a, rect_t b);
			rect_t c;
			if (is_void(b)) begin
				return a;
			end
			if (is_void(a)) begin
				return b;
			end
			if (is_unbounded(a)) begin
				return a;
			end
			if (is_unbounded(b)) begin
				return b;
			end
			c.x0 = (a.x0 < b.x0) ? a.x0 : b.x0;
			c.y0 = (a.y0 < b.y0) ? a.y0 : b.y0;
			c.x1 = (a.x1 > b.x1) ? a.x1 : b.x1;
			c.y1 = (a.y1 > b.y1) ? a.y1 : b.y1;
			return c;
		endfunction

		// Clip a rectangle to the stack top, then either grow the box with it
		// or push it as the new top.
		function void place_rect(rect_t r, bit is_clip);
			if (clip_depth > 0 && clip_depth <= STACK_DEPTH) begin
				r = clamp_rect(r, clip_cells[clip_depth - 1]);
			end
			if (!is_clip && clip_depth <= STACK_DEPTH && ignore_depth == 0) begin
				box = grow_rect(box, r);
			end
			if (is_clip && clip_depth < CLIP_MAX) begin
				clip_depth++;
				if (clip_depth <= STACK_DEPTH) begin
					clip_cells[clip_depth - 1] = r;
				end
			end
		endfunction

		function void raise_ignore();
			if (ignore_depth < IGN_MAX) begin
				ignore_depth++;
			end
		endfunction

		function void note_event(evt_item_t e);
			rect_t     r;
			res_item_t want;
			bit        under;
			r.x0  = e.rect_x0;
			r.y0  = e.rect_y0;
			r.x1  = e.rect_x1;
			r.y1  = e.rect_y1;
			under = 1'b0;
			case (e.action)
				ACT_CLEAR: begin
					box          = '0;
					clip_depth   = 0;
					ignore_depth = 0;
				end
				ACT_DRAW: place_rect(r, 1'b0);
				ACT_CLIP: place_rect(r, 1'b1);
				ACT_POP: begin
					if (clip_depth > 0) begin
						clip_depth--;
					end else begin
						under = 1'b1;
					end
				end
				ACT_MASK: begin
					place_rect(r, 1'b1);
					raise_ignore();
				end
				ACT_END_IGN: begin
					if (ignore_depth > 0) begin
						ignore_depth--;
					end
				end
				ACT_TILE: begin
					// The draw sees the ignore level from before the increment.
					place_rect(r, 1'b0);
					raise_ignore();
				end
				default: ;
			endcase
			want.box_x0        = box.x0;
			want.box_y0        = box.y0;
			want.box_x1        = box.x1;
			want.box_y1        = box.y1;
			want.clip_level    = clip_depth[CLIP_W-1:0];
			want.ignore_level  = ignore_depth[IGN_W-1:0];
			want.pop_underflow = under;
			want.over_depth    = (clip_depth > STACK_DEPTH);
			reports_due.push_back(want);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(res_item_t got);
			res_item_t want;
			if (reports_due.size() == 0) begin
				$error("result item with no event waiting for it");
				errors++;
				return;
			end
			want = reports_due.pop_front();
			compare_field("box_x0", want.box_x0, got.box_x0);
			compare_field("box_y0", want.box_y0, got.box_y0);
			compare_field("box_x1", want.box_x1, got.box_x1);
			compare_field("box_y1", want.box_y1, got.box_y1);
			compare_field("clip_level", 32'(want.clip_level), 32'(got.clip_level));
			compare_field("ignore_level", 32'(want.ignore_level),
				32'(got.ignore_level));
			compare_field("pop_underflow", 32'(want.pop_underflow),
				32'(got.pop_underflow));
			compare_field("over_depth", 32'(want.over_depth), 32'(got.over_depth));
		endfunction

		function int outstanding();
			return reports_due.size();
		endfunction
	endclass

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b1;
	logic      evt_valid = 1'b0;
	logic      evt_stall;
	evt_item_t evt       = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_item_t res;

	bbox_scoreboard sb = new();

	// When set, both sides run without gaps so that back-to-back traffic is
	// covered as well.
	bit          no_idle      = 1'b0;
	int unsigned item_count   = 0;
	int unsigned result_count = 0;
	int unsigned cycle_count  = 0;

	clip_stack_bbox_accumulator #(
		.STACK_DEPTH(STACK_DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt      (evt),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic rect_t make_rect(logic signed [31:0] x0, logic signed [31:0] y0,
			logic signed [31:0] x1, logic signed [31:0] y1);
		rect_t r;
		r.x0 = x0;
		r.y0 = y0;
		r.x1 = x1;
		r.y1 = y1;
		return r;
	endfunction

	function automatic logic signed [31:0] extreme_coord();
		case ($urandom_range(0, 4))
			0: return MIN_C;
			1: return MAX_C;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Most rectangles are small and near the origin so that clips and draws
	// overlap; the rest are empty, inverted (infinite), fully random or built
	// from extreme coordinates.
	function automatic rect_t pick_rect();
		int    x0;
		int    y0;
		int    w;
		int    h;
		rect_t r;
		x0 = $urandom_range(0, 8192) - 4096;
		y0 = $urandom_range(0, 8192) - 4096;
		w  = $urandom_range(1, 4096);
		h  = $urandom_range(1, 4096);
		r  = make_rect(x0, y0, x0 + w, y0 + h);
		case ($urandom_range(0, 9))
			6: begin
				if ($urandom_range(0, 1)) begin
					r.x1 = r.x0;
				end else begin
					r.y1 = r.y0;
				end
			end
			7: begin
				if ($urandom_range(0, 1)) begin
					r.x0 = x0 + w;
					r.x1 = x0;
				end else begin
					r.y0 = y0 + h;
					r.y1 = y0;
				end
			end
			8: r = {$urandom, $urandom, $urandom, $urandom};
			9: r = make_rect(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord());
			default: ;
		endcase
		return r;
	endfunction

	// Offer one event item after a random gap and hold it until the block
	// takes it. A zero gap keeps valid high straight into the next item.
	task automatic offer_event(logic [2:0] act, rect_t r);
		evt_item_t   e;
		int unsigned gap;
		e.action  = act;
		e.rect_x0 = r.x0;
		e.rect_y0 = r.y0;
		e.rect_x1 = r.x1;
		e.rect_y1 = r.y1;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_valid <= 1'b1;
		evt       <= e;
		do @(posedge clk); while (evt_stall);
		sb.note_event(e);
		if (act != ACT_UNUSED) begin
			item_count++;
		end
	endtask

	// Short hand-picked sequence: extreme and degenerate rectangles, every
	// action, underflow on pop and ignore release at zero.
	task automatic run_directed();
		// Widest finite rectangle into an empty box.
		offer_event(ACT_DRAW, make_rect(MIN_C, MIN_C, MAX_C, MAX_C));
		offer_event(ACT_CLEAR, '0);
		// An empty draw leaves the box alone; an inverted one makes it infinite,
		// and an infinite box absorbs whatever is drawn next.
		offer_event(ACT_DRAW, make_rect(256, 256, 256, 1024));
		offer_event(ACT_DRAW, make_rect(512, 0, -512, 256));
		offer_event(ACT_DRAW, make_rect(0, 0, 256, 256));
		offer_event(ACT_CLEAR, '0);
		// One finite clip, then a draw that overlaps it and one that misses it.
		offer_event(ACT_CLIP, make_rect(0, 0, 25600, 25600));
		offer_event(ACT_DRAW, make_rect(-2560, -2560, 2560, 2560));
		offer_event(ACT_DRAW, make_rect(30000, 30000, 40000, 40000));
		// An infinite clip takes the top as is; an empty clip stays empty and
		// hides every later draw.
		offer_event(ACT_CLIP, make_rect(0, 512, 256, -512));
		offer_event(ACT_CLIP, make_rect(100, 100, 100, 900));
		offer_event(ACT_DRAW, make_rect(0, 0, 256, 256));
		// Unwind the stack and pop once more on an empty stack.
		offer_event(ACT_POP, pick_rect());
		offer_event(ACT_POP, pick_rect());
		offer_event(ACT_POP, pick_rect());
		offer_event(ACT_POP, pick_rect());
		// Mask and tile raise the ignore level; draws under it are dropped.
		offer_event(ACT_MASK, make_rect(-256, -256, 256, 256));
		offer_event(ACT_DRAW, make_rect(MIN_C, 0, MAX_C, 256));
		offer_event(ACT_TILE, make_rect(-128, -128, 128, 128));
		offer_event(ACT_END_IGN, '0);
		offer_event(ACT_END_IGN, '0);
		offer_event(ACT_END_IGN, '0);
		offer_event(ACT_POP, '0);
		// A tile at ignore level zero still draws before raising the level.
		offer_event(ACT_TILE, make_rect(-1, -1, MAX_C, MAX_C));
		offer_event(ACT_END_IGN, '0);
		offer_event(ACT_UNUSED, {$urandom, $urandom, $urandom, $urandom});
		offer_event(ACT_DRAW, make_rect(MAX_C, MIN_C, MIN_C, MAX_C));
		offer_event(ACT_CLEAR, '0);
	endtask

	// Drive the clip depth to its ceiling and the ignore level to its ceiling.
	// Masks push like clips and also raise the ignore level, so one run of
	// pushes takes both levels up to their limits.
	task automatic run_saturation();
		no_idle = 1'b1;
		offer_event(ACT_CLEAR, '0);
		repeat (int'(CLIP_MAX) + 8) begin
			offer_event($urandom_range(0, 1) ? ACT_MASK : ACT_CLIP, pick_rect());
		end
		// Draws are skipped while the depth is past the stack capacity.
		offer_event(ACT_TILE, pick_rect());
		offer_event(ACT_DRAW, pick_rect());
		offer_event(ACT_END_IGN, '0);
		offer_event(ACT_POP, '0);
		offer_event(ACT_CLIP, pick_rect());
		offer_event(ACT_CLEAR, '0);
		no_idle = 1'b0;
	endtask

	// Balanced nesting: pushes with draws between them, then the matching pops
	// and ignore releases, with draws on the way out.
	task automatic run_nested();
		int unsigned levels;
		int unsigned ign_open;
		int unsigned n;
		levels   = $urandom_range(1, 6);
		ign_open = 0;
		if ($urandom_range(0, 2) == 0) begin
			offer_event(ACT_CLEAR, '0);
		end
		repeat (levels) begin
			if ($urandom_range(0, 4) == 0) begin
				offer_event(ACT_MASK, pick_rect());
				ign_open++;
			end else begin
				offer_event(ACT_CLIP, pick_rect());
			end
			n = $urandom_range(0, 3);
			repeat (n) begin
				if ($urandom_range(0, 5) == 0) begin
					offer_event(ACT_TILE, pick_rect());
					ign_open++;
				end else begin
					offer_event(ACT_DRAW, pick_rect());
				end
			end
		end
		repeat (levels) begin
			offer_event(ACT_POP, pick_rect());
			if ($urandom_range(0, 1)) begin
				offer_event(ACT_DRAW, pick_rect());
			end
		end
		repeat (ign_open) offer_event(ACT_END_IGN, pick_rect());
		offer_event(ACT_DRAW, pick_rect());
	endtask

	// Push to around the stack capacity, often past it, and come back down, drawing along the way.
	task automatic run_deep();
		int unsigned n;
		n = $urandom_range(STACK_DEPTH - 6, STACK_DEPTH + 14);
		offer_event(ACT_CLEAR, '0);
		repeat (n) offer_event(ACT_CLIP, pick_rect());
		offer_event(ACT_DRAW, pick_rect());
		repeat (n) begin
			offer_event(ACT_POP, '0);
			if ($urandom_range(0, 7) == 0) begin
				offer_event(ACT_DRAW, pick_rect());
			end
		end
	endtask

	// Unstructured traffic: any action code, including the unused one.
	task automatic run_noise();
		int unsigned n;
		n = $urandom_range(5, 20);
		repeat (n) offer_event(3'($urandom_range(0, 7)), pick_rect());
	endtask

	task automatic run_random();
		int unsigned target;
		int unsigned mode;
		target = item_count + RANDOM_ITEMS;
		while (item_count < target) begin
			no_idle = ($urandom_range(0, 4) == 0);
			mode    = $urandom_range(0, 15);
			if (mode <= 9) begin
				run_nested();
			end else if (mode == 10) begin
				run_deep();
			end else begin
				run_noise();
			end
		end
		no_idle = 1'b0;
	endtask

	// Receiver: stall for a random number of cycles before each result item,
	// once for a long stretch so that the block backs up into its input.
	initial begin
		int unsigned hold;
		forever begin
			if (result_count == HOLD_AT) begin
				hold = LONG_HOLD;
			end else begin
				hold = no_idle ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				res_stall <= 1'b0;
			end
			do @(posedge clk); while (!res_valid);
			sb.check_result(res);
			result_count++;
		end
	end

	// Watchdog: a run that hangs ends here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench NOT OK");
		$finish;
	end

	// Main sequence: reset, directed events, saturation, random segments, and
	// then a drain that waits for every predicted result.
	initial begin
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_saturation();
		run_random();
		evt_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
